// ----- hw/rtl/bmpu_pkg.sv -----
// Package with the shared types, constants and helpers of the bitmap pixel unpacker.
`timescale 1ns / 1ps

package bmpu_pkg;

    // Field and counter widths.
    localparam int DIM_W  = 13;
    localparam int CNT_W  = 12;
    localparam int IDX_W  = 24;
    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 2;

    // Largest image the counters cover.
    localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

    // Alpha value for pixels of the 24-bit format.
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FORMAT = 2'd2,
        REG_NONE   = 2'd3
    } cfg_reg_t;

    // Pixel formats.
    typedef enum logic {
        FMT_BGR24  = 1'b0,
        FMT_BGRA32 = 1'b1
    } pixel_format_t;

    // Position of the next byte within a pixel.
    typedef enum logic [1:0] {
        BYTE_BLUE  = 2'd0,
        BYTE_GREEN = 2'd1,
        BYTE_RED   = 2'd2,
        BYTE_ALPHA = 2'd3
    } byte_pos_t;

    // Frame geometry handed from the configuration block to the datapath.
    typedef struct packed {
        logic [DIM_W-1:0] width;      // effective width in pixels
        logic [CNT_W-1:0] col_last;   // effective width minus one
        logic [CNT_W-1:0] row_last;   // effective height minus one
        logic [1:0]       pad_bytes;  // padding bytes at the end of every row
        pixel_format_t    format;
        logic [IDX_W-1:0] start_base; // frame index of the first pixel of the bottom row
        logic             restart;    // a configuration write lands this cycle
    } geom_t;

    // Out-of-range dimensions: zero acts as one, anything above the limit as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                    input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] result;
        begin
            result = value;
            if (value == '0)
            begin
                result = {{(DIM_W-1){1'b0}}, 1'b1};
            end
            else if (value > limit)
            begin
                result = limit;
            end
            return result;
        end
    endfunction

endpackage

// ----- hw/rtl/bmpu_if.sv -----
// Valid/ready channel interfaces for raw bytes and decoded pixels.
`timescale 1ns / 1ps

interface bmpu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bmpu_pixel_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [23:0] pixel_index;
    logic        last_pixel;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output pixel_index, output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input pixel_index, input last_pixel, output ready);
endinterface

// ----- hw/rtl/bmp_pixel_data_unpacker_top.sv -----
// Top level of the bitmap pixel unpacker: byte capture, row padding skip and frame indexing.
//
//   Channel    Direction  Handshake        Contents
//   data_in    sink       valid / ready    data_byte, one raw pixel-data byte
//   pixel_out  source     valid / ready    red, green, blue, alpha, pixel_index, last_pixel
//   cfg_*      write      cfg_we           cfg_index, cfg_data (no read-back)
//
// A pixel is shown on pixel_out in the cycle after its last byte is taken. The sustained
// rate, set by the single output register, is one byte per cycle if pixel_out is ready.
// data_in.ready drops only when the next byte completes a pixel while the output
// register still holds a pixel that pixel_out has not taken.
// Reset clears all counters; the frame geometry is ready right after reset.
// A configuration write restarts the frame at the next byte.
`timescale 1ns / 1ps

module bmp_pixel_data_unpacker_top (
    input  logic                              clk,
    input  logic                              rst_n,
    bmpu_byte_if.sink                         data_in,
    bmpu_pixel_if.source                      pixel_out,
    input  logic                              cfg_we,
    input  logic [bmpu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bmpu_pkg::DIM_W-1:0]        cfg_data
);
    import bmpu_pkg::*;

    geom_t geom;

    // Frame position state.
    byte_pos_t         pos_reg;
    byte_pos_t         pos_next;
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  row_next;
    logic [1:0]        pad_reg;
    logic [1:0]        pad_next;
    logic [IDX_W-1:0]  row_base_reg;
    logic [IDX_W-1:0]  row_base_next;

    // Captured bytes of the pixel in progress.
    logic [BYTE_W-1:0] blue_reg;
    logic [BYTE_W-1:0] blue_next;
    logic [BYTE_W-1:0] green_reg;
    logic [BYTE_W-1:0] green_next;
    logic [BYTE_W-1:0] red_reg;
    logic [BYTE_W-1:0] red_next;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_red_reg;
    logic [BYTE_W-1:0] out_red_next;
    logic [BYTE_W-1:0] out_green_reg;
    logic [BYTE_W-1:0] out_green_next;
    logic [BYTE_W-1:0] out_blue_reg;
    logic [BYTE_W-1:0] out_blue_next;
    logic [BYTE_W-1:0] out_alpha_reg;
    logic [BYTE_W-1:0] out_alpha_next;
    logic [IDX_W-1:0]  out_index_reg;
    logic [IDX_W-1:0]  out_index_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              in_fire;
    logic              out_fire;
    logic              completes;
    logic              emit;
    logic              at_row_end;
    logic              at_frame_end;

    bmpu_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // The next byte finishes a pixel when no padding is due and it is the last component.
    assign completes = (pad_reg == 2'd0)
                    && ((pos_reg == BYTE_ALPHA)
                        || ((pos_reg == BYTE_RED) && (geom.format == FMT_BGR24)));

    assign at_row_end   = (col_reg >= geom.col_last);
    assign at_frame_end = at_row_end && (row_reg >= geom.row_last);

    assign data_in.ready = !completes || !out_valid_reg || pixel_out.ready;
    assign in_fire       = data_in.valid && data_in.ready;
    assign out_fire      = out_valid_reg && pixel_out.ready;
    assign emit          = in_fire && completes;

    // Byte capture, padding skip and frame counters.
    always_comb
    begin
        pos_next      = pos_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pad_next      = pad_reg;
        row_base_next = row_base_reg;
        blue_next     = blue_reg;
        green_next    = green_reg;
        red_next      = red_reg;
        if (geom.restart)
        begin
            pos_next      = BYTE_BLUE;
            col_next      = '0;
            row_next      = '0;
            pad_next      = 2'd0;
            row_base_next = geom.start_base;
        end
        else if (in_fire)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else
            begin
                case (pos_reg)
                    BYTE_BLUE:
                    begin
                        blue_next = data_in.data_byte;
                        pos_next  = BYTE_GREEN;
                    end
                    BYTE_GREEN:
                    begin
                        green_next = data_in.data_byte;
                        pos_next   = BYTE_RED;
                    end
                    BYTE_RED:
                    begin
                        red_next = data_in.data_byte;
                        pos_next = (geom.format == FMT_BGRA32) ? BYTE_ALPHA : BYTE_BLUE;
                    end
                    default:
                    begin
                        pos_next = BYTE_BLUE;
                    end
                endcase
                if (completes)
                begin
                    if (at_row_end)
                    begin
                        pad_next = geom.pad_bytes;
                        col_next = '0;
                        if (at_frame_end)
                        begin
                            row_next      = '0;
                            row_base_next = geom.start_base;
                        end
                        else
                        begin
                            row_next      = row_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            row_base_next = row_base_reg
                                          - {{(IDX_W-DIM_W){1'b0}}, geom.width};
                        end
                    end
                    else
                    begin
                        col_next = col_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                end
            end
        end
    end

    // Result register with its valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        out_alpha_next = out_alpha_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_green_next = green_reg;
            out_blue_next  = blue_reg;
            out_index_next = row_base_reg + {{(IDX_W-CNT_W){1'b0}}, col_reg};
            out_last_next  = at_frame_end;
            if (pos_reg == BYTE_RED)
            begin
                out_red_next   = data_in.data_byte;
                out_alpha_next = ALPHA_OPAQUE;
            end
            else
            begin
                out_red_next   = red_reg;
                out_alpha_next = data_in.data_byte;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= BYTE_BLUE;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_reg       <= 2'd0;
            row_base_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pad_reg       <= pad_next;
            row_base_reg  <= row_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        blue_reg      <= blue_next;
        green_reg     <= green_next;
        red_reg       <= red_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
        out_alpha_reg <= out_alpha_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.red         = out_red_reg;
    assign pixel_out.green       = out_green_reg;
    assign pixel_out.blue        = out_blue_reg;
    assign pixel_out.alpha       = out_alpha_reg;
    assign pixel_out.pixel_index = out_index_reg;
    assign pixel_out.last_pixel  = out_last_reg;

    // Padding is only ever skipped between pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg != 2'd0) |-> (pos_reg == BYTE_BLUE))
        else $error("padding pending in the middle of a pixel");

    // The column counter never runs past the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= geom.col_last)
        else $error("column counter beyond the image width");

    // The row counter never runs past the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= geom.row_last)
        else $error("row counter beyond the image height");

    // After the last pixel the frame starts over at the bottom-left corner.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && at_frame_end) |=> ((row_reg == '0) && (col_reg == '0)))
        else $error("frame did not restart after the last pixel");

endmodule

// ----- hw/rtl/bmpu_geom.sv -----
// Configuration registers and derived frame geometry of the bitmap pixel unpacker.
`timescale 1ns / 1ps

module bmpu_geom (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bmpu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bmpu_pkg::DIM_W-1:0]        cfg_data,
    output bmpu_pkg::geom_t                   geom
);
    import bmpu_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] width_next;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] height_next;
    pixel_format_t    format_reg;
    pixel_format_t    format_next;
    logic             write_hit;

    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;
    logic [DIM_W-1:0] new_width;
    logic [DIM_W-1:0] new_height;
    logic [DIM_W-1:0] eff_width_m1;
    logic [DIM_W-1:0] eff_height_m1;
    logic [DIM_W-1:0] new_height_m1;
    logic [2*DIM_W-1:0] start_product;

    // Register writes; an index beyond the list is ignored.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        format_next = format_reg;
        write_hit   = 1'b0;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:
                begin
                    width_next = cfg_data;
                    write_hit  = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = cfg_data;
                    write_hit   = 1'b1;
                end
                REG_FORMAT:
                begin
                    format_next = pixel_format_t'(cfg_data[0]);
                    write_hit   = 1'b1;
                end
                default:
                begin
                    write_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= {{(DIM_W-1){1'b0}}, 1'b1};
            height_reg <= {{(DIM_W-1){1'b0}}, 1'b1};
            format_reg <= FMT_BGR24;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            format_reg <= format_next;
        end
    end

    // Effective dimensions of the current settings.
    assign eff_width     = clamp_dim(width_reg, MAX_WIDTH);
    assign eff_height    = clamp_dim(height_reg, MAX_HEIGHT);
    assign eff_width_m1  = eff_width - {{(DIM_W-1){1'b0}}, 1'b1};
    assign eff_height_m1 = eff_height - {{(DIM_W-1){1'b0}}, 1'b1};

    // Start of the bottom row, from the settings that hold after this cycle.
    assign new_width     = clamp_dim(width_next, MAX_WIDTH);
    assign new_height    = clamp_dim(height_next, MAX_HEIGHT);
    assign new_height_m1 = new_height - {{(DIM_W-1){1'b0}}, 1'b1};
    assign start_product = new_height_m1 * new_width;

    // In 24-bit format a row of w pixels needs w mod 4 padding bytes.
    assign geom.width      = eff_width;
    assign geom.col_last   = eff_width_m1[CNT_W-1:0];
    assign geom.row_last   = eff_height_m1[CNT_W-1:0];
    assign geom.pad_bytes  = (format_reg == FMT_BGRA32) ? 2'd0 : eff_width[1:0];
    assign geom.format     = format_reg;
    assign geom.start_base = start_product[IDX_W-1:0];
    assign geom.restart    = write_hit;

endmodule
